// ===== sv/wopmc_pkg.sv =====
// Shared constants and arithmetic helpers for the worst-of put Monte Carlo core.
// Depends on nothing; imported by worst_of_put_mc_greeks_core.
package wopmc_pkg;

	localparam int unsigned MaxUnderlyings = 4;
	localparam logic [31:0] MaxPaths = 32'd16777216;
	localparam int unsigned DivWidth = 160;
	localparam int unsigned CfgIdxWidth = 3;

	// Configuration register indexes.
	localparam logic [CfgIdxWidth-1:0] REG_STRIKE = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_BUMP   = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_SPOT_A = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_SPOT_B = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_SPOT_C = 3'd4;
	localparam logic [CfgIdxWidth-1:0] REG_SPOT_D = 3'd5;
	localparam logic [CfgIdxWidth-1:0] REG_COUNT  = 3'd6;

	typedef logic [31:0] ratio_t;
	typedef logic [63:0] word_t;

	// Floored put payoff on a worst ratio.
	function automatic ratio_t put_payoff(input ratio_t strike, input ratio_t worst);
		put_payoff = (strike > worst) ? (strike - worst) : 32'd0;
	endfunction

	// Applies a sign to an unsigned quotient and saturates to the signed range.
	function automatic word_t sign_sat(input word_t q, input logic neg);
		if (q[63]) begin
			sign_sat = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			sign_sat = neg ? (64'd0 - q) : q;
		end
	endfunction

endpackage

// ===== sv/worst_of_put_mc_greeks_core.sv =====
// Top level of the worst-of put Monte Carlo pricer with bump-and-revalue greeks.
// Depends on wopmc_pkg for constants and the payoff and saturation helpers.

// One input transaction is one simulated path. All divisions go through one
// shared restoring divider that retires one quotient bit per cycle, and one
// 32x31 multiplier serves the ratio bumps and the bump-spot products. A path
// that is not the last is dominated by the N ratio divisions of 60 bits each,
// for N used underlyings. The last path adds the closing pass: ten means, per
// used underlying a delta (with its bump-spot product) and a gamma (two 160-bit
// divisions), and the delta-dollar division. The input is not ready during that
// work; a finished result sits in the output register and the next path is
// taken while it waits.
module worst_of_put_mc_greeks_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// price_a [31:0], price_b [63:32], price_c [95:64], price_d [127:96]
	input  logic [127:0]  s_tdata,
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	// present_value, delta_a..d, gamma_a..d, taylor_forecast, shocked_change,
	// delta_dollar: 64 bits each from the lowest bit up
	output logic [767:0]  m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [wopmc_pkg::CfgIdxWidth-1:0] cfg_index,
	input  logic [31:0]   cfg_data
);
	import wopmc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RATIO = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_WB    = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_POST  = 4'd6;
	localparam logic [3:0] ST_MEAN  = 4'd7;
	localparam logic [3:0] ST_BS    = 4'd8;
	localparam logic [3:0] ST_DLT   = 4'd9;
	localparam logic [3:0] ST_GM1   = 4'd10;
	localparam logic [3:0] ST_DD    = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	localparam logic [2:0] OP_RATIO = 3'd0;
	localparam logic [2:0] OP_MEAN  = 3'd1;
	localparam logic [2:0] OP_DELTA = 3'd2;
	localparam logic [2:0] OP_GAM1  = 3'd3;
	localparam logic [2:0] OP_GAM2  = 3'd4;
	localparam logic [2:0] OP_DD    = 3'd5;

	// Configuration registers.
	ratio_t      strike_q;
	logic [30:0] bump_q;
	ratio_t      spot_q [MaxUnderlyings];
	logic [2:0]  ucnt_q;

	// Sequencer and path data.
	logic [3:0]   state_q;
	logic [2:0]   k_q;
	logic [3:0]   f_q;
	logic [127:0] price_q;
	logic         last_q;
	ratio_t       ratio_q [MaxUnderlyings];
	logic [62:0]  prod_q;
	logic [63:0]  bs_q;
	logic         sign_q;

	// Accumulators.
	logic [31:0] path_q;
	word_t       base_sum_q, shock_sum_q;
	word_t       up_sum_q [MaxUnderlyings];
	word_t       dn_sum_q [MaxUnderlyings];

	// Means and greeks of the closing pass.
	word_t b_q, s_q, dd_q;
	word_t u_q [MaxUnderlyings];
	word_t d_q [MaxUnderlyings];
	word_t delta_q [MaxUnderlyings];
	word_t gamma_q [MaxUnderlyings];

	// Shared divider.
	logic [DivWidth-1:0] dnum_q;
	logic [63:0]         drem_q;
	logic [63:0]         dden_q;
	logic [7:0]          dcnt_q;
	logic [2:0]          op_q;

	logic [2:0]  n_used;
	logic        accum_ok;
	ratio_t      worst;
	logic [64:0] trial;
	logic        trial_ge;
	word_t       q64;
	ratio_t      bump_opnd;
	ratio_t      mul_opnd;
	logic [62:0] mul_prod;
	logic [63:0] rounded;
	ratio_t      bq;
	ratio_t      r_up, r_dn;
	ratio_t      wu, wd;
	word_t       dd_num, forecast;
	word_t       dlt_num, gam_num;
	logic [1:0]  ki;

	assign ki        = k_q[1:0];
	assign n_used    = (ucnt_q > 3'(MaxUnderlyings)) ? 3'(MaxUnderlyings) : ucnt_q;
	assign accum_ok  = path_q < MaxPaths;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Divider step: shift in one numerator bit and try to subtract.
	assign trial    = {drem_q, dnum_q[DivWidth-1]};
	assign trial_ge = trial >= {1'b0, dden_q};
	assign q64      = (|dnum_q[DivWidth-1:64]) ? '1 : dnum_q[63:0];

	// Worst ratio over the used underlyings.
	always_comb begin
		worst = '1;
		for (int j = 0; j < MaxUnderlyings; j++) begin
			if (3'(j) < n_used && ratio_q[j] < worst) begin
				worst = ratio_q[j];
			end
		end
	end

	// Shared multiplier: ratio bumps, and the bump-spot product of the closing pass.
	assign bump_opnd = (k_q < n_used) ? ratio_q[ki] : worst;
	assign mul_opnd  = (state_q == ST_BS) ? spot_q[ki] : bump_opnd;
	assign mul_prod  = mul_opnd * bump_q;

	// Bumped ratios from the registered product, rounded half up.
	assign rounded   = {1'b0, prod_q} + 64'h0000_0000_8000_0000;
	assign bq        = rounded[63:32];
	assign r_dn      = bump_opnd - bq;
	always_comb begin
		logic [32:0] sum_up;
		sum_up = {1'b0, bump_opnd} + {1'b0, bq};
		r_up   = sum_up[32] ? '1 : sum_up[31:0];
	end

	// Worst ratio with underlying k bumped up and down.
	always_comb begin
		wu = '1;
		wd = '1;
		for (int j = 0; j < MaxUnderlyings; j++) begin
			if (3'(j) < n_used) begin
				if (3'(j) == k_q) begin
					if (r_up < wu) wu = r_up;
					if (r_dn < wd) wd = r_dn;
				end else begin
					if (ratio_q[j] < wu) wu = ratio_q[j];
					if (ratio_q[j] < wd) wd = ratio_q[j];
				end
			end
		end
	end

	// Sums over used underlyings for the delta-dollar and the Taylor forecast.
	always_comb begin
		dd_num   = '0;
		forecast = '0;
		for (int j = 0; j < MaxUnderlyings; j++) begin
			if (3'(j) < n_used) begin
				dd_num   = dd_num + u_q[j] - d_q[j];
				forecast = forecast + u_q[j] - b_q;
			end
		end
	end

	assign dlt_num = u_q[ki] - d_q[ki];
	assign gam_num = u_q[ki] - (b_q << 1) + d_q[ki];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_q <= 32'd268435456;
			bump_q   <= 31'd42949673;
			ucnt_q   <= 3'd1;
			for (int j = 0; j < MaxUnderlyings; j++) spot_q[j] <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STRIKE: strike_q  <= cfg_data;
				REG_BUMP:   bump_q    <= cfg_data[30:0];
				REG_SPOT_A: spot_q[0] <= cfg_data;
				REG_SPOT_B: spot_q[1] <= cfg_data;
				REG_SPOT_C: spot_q[2] <= cfg_data;
				REG_SPOT_D: spot_q[3] <= cfg_data;
				REG_COUNT:  ucnt_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_EMIT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!m_tvalid || m_tready)) begin
			m_tdata[63:0]    <= (64'd1 << 40) - b_q;
			m_tdata[127:64]  <= delta_q[0];
			m_tdata[191:128] <= delta_q[1];
			m_tdata[255:192] <= delta_q[2];
			m_tdata[319:256] <= delta_q[3];
			m_tdata[383:320] <= gamma_q[0];
			m_tdata[447:384] <= gamma_q[1];
			m_tdata[511:448] <= gamma_q[2];
			m_tdata[575:512] <= gamma_q[3];
			m_tdata[639:576] <= forecast;
			m_tdata[703:640] <= s_q - b_q;
			m_tdata[767:704] <= dd_q;
		end
	end

	// Payload and working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				price_q <= s_tdata;
				last_q  <= s_tlast;
			end
			ST_RATIO: begin
				dnum_q <= {price_q[32*ki +: 32], 128'd0};
				dden_q <= {32'd0, spot_q[ki]};
				drem_q <= '0;
				dcnt_q <= 8'd60;
				op_q   <= OP_RATIO;
			end
			ST_DIV: begin
				dnum_q <= {dnum_q[DivWidth-2:0], trial_ge};
				drem_q <= trial_ge ? 64'(trial - {1'b0, dden_q}) : trial[63:0];
				dcnt_q <= dcnt_q - 8'd1;
			end
			ST_WB: begin
				case (op_q)
					OP_RATIO: ratio_q[ki] <= (|q64[63:32]) ? '1 : q64[31:0];
					OP_MEAN: begin
						case (f_q)
							4'd0: b_q <= (path_q == '0) ? '0 : q64;
							4'd1: s_q <= (path_q == '0) ? '0 : q64;
							4'd2, 4'd3, 4'd4, 4'd5:
								u_q[2'(f_q - 4'd2)] <= (path_q == '0) ? '0 : q64;
							default:
								d_q[2'(f_q - 4'd6)] <= (path_q == '0) ? '0 : q64;
						endcase
					end
					OP_DELTA: delta_q[ki] <= (bs_q == '0) ? '0 : sign_sat(q64, sign_q);
					OP_GAM1: begin
						drem_q <= '0;
						dcnt_q <= 8'(DivWidth);
						op_q   <= OP_GAM2;
					end
					OP_GAM2: gamma_q[ki] <= (bs_q == '0) ? '0 : sign_sat(q64, sign_q);
					default: dd_q <= (bump_q == '0) ? '0 : sign_sat(q64, sign_q);
				endcase
			end
			ST_MUL: prod_q <= mul_prod;
			ST_POST: begin
				for (int j = 0; j < MaxUnderlyings; j++) begin
					delta_q[j] <= '0;
					gamma_q[j] <= '0;
				end
			end
			ST_MEAN: begin
				case (f_q)
					4'd0: dnum_q <= {base_sum_q, 96'd0};
					4'd1: dnum_q <= {shock_sum_q, 96'd0};
					4'd2, 4'd3, 4'd4, 4'd5: dnum_q <= {up_sum_q[2'(f_q - 4'd2)], 96'd0};
					default: dnum_q <= {dn_sum_q[2'(f_q - 4'd6)], 96'd0};
				endcase
				dden_q <= {32'd0, path_q};
				drem_q <= '0;
				dcnt_q <= 8'd76;
				op_q   <= OP_MEAN;
			end
			ST_BS: bs_q <= {1'b0, mul_prod};
			ST_DLT: begin
				sign_q <= dlt_num[63];
				dnum_q <= {(dlt_num[63] ? 64'd0 - dlt_num : dlt_num), 96'd0};
				dden_q <= bs_q;
				drem_q <= '0;
				dcnt_q <= 8'd111;
				op_q   <= OP_DELTA;
			end
			ST_GM1: begin
				sign_q <= gam_num[63];
				dnum_q <= {(gam_num[63] ? 64'd0 - gam_num : gam_num), 96'd0};
				dden_q <= bs_q;
				drem_q <= '0;
				dcnt_q <= 8'(DivWidth);
				op_q   <= OP_GAM1;
			end
			ST_DD: begin
				sign_q <= dd_num[63];
				dnum_q <= {(dd_num[63] ? 64'd0 - dd_num : dd_num), 96'd0};
				dden_q <= {33'd0, bump_q};
				drem_q <= '0;
				dcnt_q <= 8'd95;
				op_q   <= OP_DD;
			end
			default: ;
		endcase
	end

	// Control sequencer and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			f_q         <= '0;
			path_q      <= '0;
			base_sum_q  <= '0;
			shock_sum_q <= '0;
			for (int j = 0; j < MaxUnderlyings; j++) begin
				up_sum_q[j] <= '0;
				dn_sum_q[j] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						k_q <= '0;
						if (!accum_ok) begin
							state_q <= ST_POST;
						end else if (n_used == '0) begin
							path_q  <= path_q + 32'd1;
							state_q <= ST_POST;
						end else begin
							state_q <= ST_RATIO;
						end
					end
				end
				ST_RATIO: begin
					if (k_q < n_used) begin
						state_q <= ST_DIV;
					end else begin
						k_q     <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (dcnt_q == 8'd1) state_q <= ST_WB;
				end
				ST_WB: begin
					case (op_q)
						OP_RATIO: begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_RATIO;
						end
						OP_MEAN: begin
							f_q     <= f_q + 4'd1;
							state_q <= ST_MEAN;
						end
						OP_DELTA: state_q <= ST_GM1;
						OP_GAM1:  state_q <= ST_DIV;
						OP_GAM2: begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_BS;
						end
						default: state_q <= ST_EMIT;
					endcase
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (k_q < n_used) begin
						up_sum_q[ki] <= up_sum_q[ki] + {32'd0, put_payoff(strike_q, wu)};
						dn_sum_q[ki] <= dn_sum_q[ki] + {32'd0, put_payoff(strike_q, wd)};
						k_q          <= k_q + 3'd1;
						state_q      <= ST_MUL;
					end else begin
						base_sum_q  <= base_sum_q + {32'd0, put_payoff(strike_q, worst)};
						shock_sum_q <= shock_sum_q + {32'd0, put_payoff(strike_q, r_up)};
						path_q      <= path_q + 32'd1;
						state_q     <= ST_POST;
					end
				end
				ST_POST: begin
					f_q     <= '0;
					state_q <= last_q ? ST_MEAN : ST_IDLE;
				end
				ST_MEAN: begin
					if (f_q < 4'd10) begin
						state_q <= ST_DIV;
					end else begin
						k_q     <= '0;
						state_q <= ST_BS;
					end
				end
				ST_BS:  state_q <= (k_q < n_used) ? ST_DLT : ST_DD;
				ST_DLT: state_q <= ST_DIV;
				ST_GM1: state_q <= ST_DIV;
				ST_DD:  state_q <= ST_DIV;
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						path_q      <= '0;
						base_sum_q  <= '0;
						shock_sum_q <= '0;
						for (int j = 0; j < MaxUnderlyings; j++) begin
							up_sum_q[j] <= '0;
							dn_sum_q[j] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The divider never runs with an exhausted bit count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dcnt_q != 8'd0))
		else $error("divider running with zero bit count");

	// An accepted path always starts work.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted path left the sequencer idle");

	// Emitting a result loads the output and clears the trade state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && (!m_tvalid || m_tready)) |=> (m_tvalid && path_q == '0))
		else $error("result emitted without clearing the trade");
`endif

endmodule
